// File: rtl/cds_pkg.sv
// cds_pkg: shared types, constants and the month-length table for the
// calendar date stepper. No dependencies.
`timescale 1ns / 1ps

package cds_pkg;

  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int LOAD_YEAR_W = 16;
  localparam int COUNT_W     = 24;
  localparam int CMD_W       = 3;
  localparam int QUOT_W      = 16;   // floor((2^24 - 1) / 365) fits in 16 bits
  localparam int REM_W       = 9;    // remainder below 365
  localparam int PROD_W      = 2 * COUNT_W;

  localparam logic [COUNT_W-1:0] DAYS_PER_YEAR = 24'd365;
  localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;

  // ceil(2^32 / 365); exact quotient for every 24-bit count
  localparam int RECIP_SHIFT = 32;
  localparam logic [COUNT_W-1:0] DAYS_RECIP = 24'd11767034;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 3'd0,
    CMD_NEXT = 3'd1,
    CMD_PREV = 3'd2,
    CMD_ADD  = 3'd3,
    CMD_SUB  = 3'd4
  } cmd_code_t;

  // controller -> datapath
  typedef struct packed {
    logic cap;       // capture input fields
    logic load;      // apply clamped load
    logic mul;       // count times reciprocal
    logic quot;      // take quotient
    logic rem;       // year step and remainder
    logic walk;      // one month step of the walk
    logic is_sub;    // walk backwards
    logic out_load;  // update result register
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;
  } stat_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                   len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/cds_chan_if.sv
// cds_chan_if: valid/ready channel interfaces for the date stepper's input
// and result sides. Depends on cds_pkg.
`timescale 1ns / 1ps

interface cds_in_if
  import cds_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [DAY_W-1:0]       load_day;
  logic [MONTH_W-1:0]     load_month;
  logic [LOAD_YEAR_W-1:0] load_year;
  logic [COUNT_W-1:0]     day_count;

  modport source (output valid, command, load_day, load_month, load_year, day_count,
                  input ready);
  modport sink   (input valid, command, load_day, load_month, load_year, day_count,
                  output ready);
endinterface

interface cds_out_if
  import cds_pkg::*;
#(
  parameter int YEAR_WIDTH = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [DAY_W-1:0]      cur_day;
  logic [MONTH_W-1:0]    cur_month;
  logic [YEAR_WIDTH-1:0] cur_year;

  modport source (output valid, cur_day, cur_month, cur_year, input ready);
  modport sink   (input valid, cur_day, cur_month, cur_year, output ready);
endinterface

// File: rtl/cds_ctrl.sv
// cds_ctrl: sequencing state machine of the date stepper.
// Depends on cds_pkg; drives the datapath through ctrl_t, reads stat_t.
`timescale 1ns / 1ps

module cds_ctrl
  import cds_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output ctrl_t            ctl,
  input  stat_t            stat
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_QUOT = 7'b0001000,
    S_REM  = 7'b0010000,
    S_WALK = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   sub_r, sub_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   publish;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign publish   = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    sub_nxt   = sub_r;
    ctl       = '0;
    ctl.is_sub = sub_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.cap = 1'b1;
          case (in_command)
            CMD_LOAD: state_nxt = S_LOAD;
            CMD_NEXT: begin
              sub_nxt   = 1'b0;
              state_nxt = S_WALK;
            end
            CMD_PREV: begin
              sub_nxt   = 1'b1;
              state_nxt = S_WALK;
            end
            CMD_ADD: begin
              sub_nxt   = 1'b0;
              state_nxt = S_MUL;
            end
            CMD_SUB: begin
              sub_nxt   = 1'b1;
              state_nxt = S_MUL;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_LOAD: begin
        ctl.load  = 1'b1;
        state_nxt = S_DONE;
      end
      S_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = S_QUOT;
      end
      S_QUOT: begin
        ctl.quot  = 1'b1;
        state_nxt = S_REM;
      end
      S_REM: begin
        ctl.rem   = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        ctl.walk = 1'b1;
        if (stat.walk_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (publish) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || publish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sub_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/cds_dpath.sv
// cds_dpath: date registers, year/remainder split and month walk unit.
// Depends on cds_pkg; steered by cds_ctrl via ctrl_t.
`timescale 1ns / 1ps

module cds_dpath
  import cds_pkg::*;
#(
  parameter int YEAR_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctrl_t                  ctl,
  output stat_t                  stat,
  input  logic [DAY_W-1:0]       in_load_day,
  input  logic [MONTH_W-1:0]     in_load_month,
  input  logic [LOAD_YEAR_W-1:0] in_load_year,
  input  logic [COUNT_W-1:0]     in_day_count,
  output logic [DAY_W-1:0]       out_cur_day,
  output logic [MONTH_W-1:0]     out_cur_month,
  output logic [YEAR_WIDTH-1:0]  out_cur_year
);

  // live date
  logic [DAY_W-1:0]      day_r, day_nxt;
  logic [MONTH_W-1:0]    month_r, month_nxt;
  logic [YEAR_WIDTH-1:0] year_r, year_nxt;

  // captured operands and intermediates
  logic [DAY_W-1:0]       ld_day_r, ld_day_nxt;
  logic [MONTH_W-1:0]     ld_month_r, ld_month_nxt;
  logic [LOAD_YEAR_W-1:0] ld_year_r, ld_year_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [QUOT_W-1:0]      quot_r, quot_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;

  // result register
  logic [DAY_W-1:0]      res_day_r, res_day_nxt;
  logic [MONTH_W-1:0]    res_month_r, res_month_nxt;
  logic [YEAR_WIDTH-1:0] res_year_r, res_year_nxt;

  logic [DAY_W-1:0]      cur_len;
  logic [DAY_W-1:0]      left_in_month;
  logic [MONTH_W-1:0]    prev_month;
  logic [MONTH_W-1:0]    clamp_month;
  logic [DAY_W-1:0]      clamp_len;
  logic [COUNT_W-1:0]    rem_full;
  logic [YEAR_WIDTH-1:0] quot_ext;

  assign cur_len       = month_len(month_r);
  assign left_in_month = cur_len - day_r;
  assign prev_month    = (month_r <= 4'd1) ? MONTHS_PER_YEAR : month_r - 4'd1;
  assign rem_full      = count_r - ({{(COUNT_W-QUOT_W){1'b0}}, quot_r} * DAYS_PER_YEAR);
  assign quot_ext      = YEAR_WIDTH'(quot_r);

  always_comb begin
    if (ld_month_r == 4'd0) begin
      clamp_month = 4'd1;
    end else if (ld_month_r > MONTHS_PER_YEAR) begin
      clamp_month = MONTHS_PER_YEAR;
    end else begin
      clamp_month = ld_month_r;
    end
  end
  assign clamp_len = month_len(clamp_month);

  // walk finishes once the rest fits inside the current month
  assign stat.walk_done = ctl.is_sub ? (rem_r < REM_W'(day_r))
                                     : (rem_r <= REM_W'(left_in_month));

  always_comb begin
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    ld_day_nxt    = ld_day_r;
    ld_month_nxt  = ld_month_r;
    ld_year_nxt   = ld_year_r;
    count_nxt     = count_r;
    prod_nxt      = prod_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    res_day_nxt   = res_day_r;
    res_month_nxt = res_month_r;
    res_year_nxt  = res_year_r;

    if (ctl.cap) begin
      ld_day_nxt   = in_load_day;
      ld_month_nxt = in_load_month;
      ld_year_nxt  = in_load_year;
      count_nxt    = in_day_count;
      rem_nxt      = REM_W'(1);   // single-day steps walk one day
    end

    if (ctl.load) begin
      month_nxt = clamp_month;
      year_nxt  = YEAR_WIDTH'(ld_year_r);
      if (ld_day_r == 5'd0) begin
        day_nxt = 5'd1;
      end else if (ld_day_r > clamp_len) begin
        day_nxt = clamp_len;
      end else begin
        day_nxt = ld_day_r;
      end
    end

    if (ctl.mul) begin
      prod_nxt = PROD_W'(count_r) * PROD_W'(DAYS_RECIP);
    end

    if (ctl.quot) begin
      quot_nxt = prod_r[RECIP_SHIFT +: QUOT_W];
    end

    if (ctl.rem) begin
      rem_nxt  = rem_full[REM_W-1:0];
      year_nxt = ctl.is_sub ? (year_r - quot_ext) : (year_r + quot_ext);
    end

    if (ctl.walk) begin
      if (ctl.is_sub) begin
        if (stat.walk_done) begin
          day_nxt = day_r - rem_r[DAY_W-1:0];
        end else begin
          rem_nxt   = rem_r - REM_W'(day_r);
          month_nxt = prev_month;
          day_nxt   = month_len(prev_month);
          if (month_r <= 4'd1) begin
            year_nxt = year_r - YEAR_WIDTH'(1);
          end
        end
      end else begin
        if (stat.walk_done) begin
          day_nxt = day_r + rem_r[DAY_W-1:0];
        end else begin
          rem_nxt = rem_r - REM_W'(left_in_month) - REM_W'(1);
          day_nxt = 5'd1;
          if (month_r >= MONTHS_PER_YEAR) begin
            month_nxt = 4'd1;
            year_nxt  = year_r + YEAR_WIDTH'(1);
          end else begin
            month_nxt = month_r + 4'd1;
          end
        end
      end
    end

    if (ctl.out_load) begin
      res_day_nxt   = day_r;
      res_month_nxt = month_r;
      res_year_nxt  = year_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= 5'd1;
      month_r <= 4'd1;
      year_r  <= YEAR_WIDTH'(1);
    end else begin
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ld_day_r    <= ld_day_nxt;
    ld_month_r  <= ld_month_nxt;
    ld_year_r   <= ld_year_nxt;
    count_r     <= count_nxt;
    prod_r      <= prod_nxt;
    quot_r      <= quot_nxt;
    rem_r       <= rem_nxt;
    res_day_r   <= res_day_nxt;
    res_month_r <= res_month_nxt;
    res_year_r  <= res_year_nxt;
  end

  assign out_cur_day   = res_day_r;
  assign out_cur_month = res_month_r;
  assign out_cur_year  = res_year_r;

endmodule

// File: rtl/calendar_date_stepper.sv
// calendar_date_stepper: top level of the 365-day date stepper.
// Depends on cds_pkg, cds_chan_if, cds_ctrl and cds_dpath.
`timescale 1ns / 1ps
//
//  channel   dir  handshake              payload
//  in_chan   in   valid/ready (sink)     command, load_day, load_month, load_year,
//                                        day_count
//  out_chan  out  valid/ready (source)   cur_day, cur_month, cur_year
//
//  Sequencing: one command in flight. Load runs S_LOAD, next/previous day one or
//  two walk steps, add/subtract S_MUL, S_QUOT, S_REM and 1..13 month steps of the
//  walk unit (one month per cycle); unused codes go straight to S_DONE. The next
//  command is taken the cycle after the result enters the output register.
//  Reset: synchronous, active low; date returns to 1 January of year 1.
//  Stalls: the result register holds while out_chan.ready is low; a new command
//  is taken meanwhile, and its result waits until the register frees.

module calendar_date_stepper
  import cds_pkg::*;
#(
  parameter int YEAR_WIDTH = 16   // year wraps modulo 2^YEAR_WIDTH, 8..32
) (
  input  logic clk,
  input  logic rst_n,
  cds_in_if.sink    in_chan,
  cds_out_if.source out_chan
);

  ctrl_t ctl;
  stat_t stat;

  // controller: accepts a transfer, sequences the split and the walk,
  // and owns the result valid flag
  cds_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.command),
    .in_ready   (in_chan.ready),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .ctl        (ctl),
    .stat       (stat)
  );

  // datapath: date state, reciprocal multiply for count / 365,
  // month walk and the result register
  cds_dpath #(
    .YEAR_WIDTH (YEAR_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .stat          (stat),
    .in_load_day   (in_chan.load_day),
    .in_load_month (in_chan.load_month),
    .in_load_year  (in_chan.load_year),
    .in_day_count  (in_chan.day_count),
    .out_cur_day   (out_chan.cur_day),
    .out_cur_month (out_chan.cur_month),
    .out_cur_year  (out_chan.cur_year)
  );

endmodule

// File: rtl/cds_checker.sv
// cds_checker: port-level checks for calendar_date_stepper, bound to the top.
// Depends on cds_pkg.
`timescale 1ns / 1ps

module cds_checker
  import cds_pkg::*;
#(
  parameter int YEAR_WIDTH = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DAY_W-1:0]      cur_day,
  input logic [MONTH_W-1:0]    cur_month,
  input logic [YEAR_WIDTH-1:0] cur_year
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cur_day) && $stable(cur_month)
      && $stable(cur_year))
    else $error("result changed while stalled");

  // one command at a time: ready drops after a transfer
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while busy");

  // every result is a valid date
  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cur_month >= 4'd1 && cur_month <= MONTHS_PER_YEAR && cur_day >= 5'd1
      && cur_day <= month_len(cur_month))
    else $error("result is not a valid date");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind calendar_date_stepper cds_checker #(
  .YEAR_WIDTH (YEAR_WIDTH)
) u_cds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .cur_day   (out_chan.cur_day),
  .cur_month (out_chan.cur_month),
  .cur_year  (out_chan.cur_year)
);

// File: test/tb_calendar_date_stepper.sv
// tb_calendar_date_stepper: self-checking bench for the 365-day date stepper.
// Depends on cds_pkg, cds_chan_if and calendar_date_stepper.
`timescale 1ns / 1ps

module tb_calendar_date_stepper;
  import cds_pkg::*;

  localparam int YEAR_W       = 16;
  localparam int CLK_HALF_NS  = 10;
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off, fills the block
  localparam int TAIL_CYCLES  = 30;
  localparam int TIMEOUT_NS   = 10_000_000;
  localparam int PHASE_ITEMS  = 670;

  // codes 5..7 are not commands; the date must stay put
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]       command;
    logic [DAY_W-1:0]       load_day;
    logic [MONTH_W-1:0]     load_month;
    logic [LOAD_YEAR_W-1:0] load_year;
    logic [COUNT_W-1:0]     day_count;
  } date_cmd_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } cal_date_t;

  logic clk;
  logic rst_n;

  cds_in_if                       in_bus ();
  cds_out_if #(.YEAR_WIDTH(YEAR_W)) out_bus ();

  calendar_date_stepper #(
    .YEAR_WIDTH(YEAR_W)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus),
    .out_chan(out_bus)
  );

  // Bench state: commands waiting to be driven, dates waiting to be seen,
  // and the bench's own copy of the stored date.
  date_cmd_t   pending_cmds[$];
  cal_date_t   expected_dates[$];
  cal_date_t   model_date;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned phase_id;
  logic        hold_off;

  int unsigned queued_count;
  int unsigned accepted_count;
  int unsigned dates_checked;
  int unsigned count_mismatches;
  int unsigned cmd_tally [0:7];

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #(CLK_HALF_NS) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Date arithmetic, kept independent of the design's package helpers
  // ---------------------------------------------------------------------------

  // Month lengths; anything outside 1..12 counts as 31 days.
  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] n;
    case (m)
      4'd2:                    n = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic cal_date_t roll_month_fwd(input cal_date_t d);
    cal_date_t r;
    r = d;
    if (d.month >= MONTHS_PER_YEAR) begin
      r.month = 4'd1;
      r.year  = d.year + 1'b1;
    end else begin
      r.month = d.month + 1'b1;
    end
    return r;
  endfunction

  function automatic cal_date_t roll_month_back(input cal_date_t d);
    cal_date_t r;
    r = d;
    if (d.month <= 4'd1) begin
      r.month = MONTHS_PER_YEAR;
      r.year  = d.year - 1'b1;
    end else begin
      r.month = d.month - 1'b1;
    end
    return r;
  endfunction

  // Date after one command. Add/subtract moves whole years first, then walks
  // the remainder month by month.
  function automatic cal_date_t advance_date(input cal_date_t cur, input date_cmd_t c);
    cal_date_t          d;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   dd;
    int unsigned        rest;
    int unsigned        span;
    logic               done;
    d    = cur;
    done = 1'b0;
    rest = int'(c.day_count) % int'(DAYS_PER_YEAR);
    case (c.command)
      CMD_LOAD: begin
        m  = c.load_month;
        dd = c.load_day;
        if (m < 4'd1) m = 4'd1;
        if (m > MONTHS_PER_YEAR) m = MONTHS_PER_YEAR;
        if (dd < 5'd1) dd = 5'd1;
        if (dd > days_in_month(m)) dd = days_in_month(m);
        d.day   = dd;
        d.month = m;
        d.year  = c.load_year;
      end
      CMD_NEXT: begin
        if (d.day >= days_in_month(d.month)) begin
          d     = roll_month_fwd(d);
          d.day = 5'd1;
        end else begin
          d.day = d.day + 1'b1;
        end
      end
      CMD_PREV: begin
        if (d.day <= 5'd1) begin
          d     = roll_month_back(d);
          d.day = days_in_month(d.month);
        end else begin
          d.day = d.day - 1'b1;
        end
      end
      CMD_ADD: begin
        d.year = d.year + YEAR_W'(int'(c.day_count) / int'(DAYS_PER_YEAR));
        while (!done) begin
          span = int'(days_in_month(d.month)) - int'(d.day);
          if (rest <= span) begin
            d.day = d.day + DAY_W'(rest);
            done  = 1'b1;
          end else begin
            rest  = rest - (span + 1);
            d.day = 5'd1;
            d     = roll_month_fwd(d);
          end
        end
      end
      CMD_SUB: begin
        d.year = d.year - YEAR_W'(int'(c.day_count) / int'(DAYS_PER_YEAR));
        while (!done) begin
          if (rest < int'(d.day)) begin
            d.day = d.day - DAY_W'(rest);
            done  = 1'b1;
          end else begin
            rest  = rest - int'(d.day);
            d     = roll_month_back(d);
            d.day = days_in_month(d.month);
          end
        end
      end
      default: ;
    endcase
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [DAY_W-1:0] dy,
                           input logic [MONTH_W-1:0] mo, input logic [LOAD_YEAR_W-1:0] yr,
                           input logic [COUNT_W-1:0] cnt);
    date_cmd_t c;
    c.command    = cmd;
    c.load_day   = dy;
    c.load_month = mo;
    c.load_year  = yr;
    c.day_count  = cnt;
    pending_cmds.push_back(c);
    queued_count++;
  endtask

  // Mostly short walks, some medium, a few across the whole 24-bit range.
  function automatic logic [COUNT_W-1:0] pick_day_count();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return COUNT_W'($urandom_range(0, 40));
    if (sel < 85) return COUNT_W'($urandom_range(0, 800));
    return COUNT_W'($urandom);
  endfunction

  // One random command. Fields a command does not use carry random noise.
  task automatic queue_random_cmd();
    int unsigned        sel;
    logic [MONTH_W-1:0] mo;
    logic [DAY_W-1:0]   dy;
    sel = $urandom_range(0, 99);
    mo  = MONTH_W'($urandom);
    dy  = DAY_W'($urandom);
    if (sel < 12) begin
      // well-formed load
      mo = MONTH_W'($urandom_range(1, 12));
      dy = DAY_W'($urandom_range(1, days_in_month(mo)));
      queue_cmd(CMD_LOAD, dy, mo, LOAD_YEAR_W'($urandom), COUNT_W'($urandom));
    end else if (sel < 17) begin
      // load with any field bits: zero, over-long day, month 13..15
      queue_cmd(CMD_LOAD, dy, mo, LOAD_YEAR_W'($urandom), COUNT_W'($urandom));
    end else if (sel < 34) begin
      queue_cmd(CMD_NEXT, dy, mo, LOAD_YEAR_W'($urandom), COUNT_W'($urandom));
    end else if (sel < 51) begin
      queue_cmd(CMD_PREV, dy, mo, LOAD_YEAR_W'($urandom), COUNT_W'($urandom));
    end else if (sel < 71) begin
      queue_cmd(CMD_ADD, dy, mo, LOAD_YEAR_W'($urandom), pick_day_count());
    end else if (sel < 92) begin
      queue_cmd(CMD_SUB, dy, mo, LOAD_YEAR_W'($urandom), pick_day_count());
    end else begin
      queue_cmd(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), dy, mo,
                LOAD_YEAR_W'($urandom), COUNT_W'($urandom));
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
    count_mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the head of pending_cmds. On a transfer the command is run
  // through the predictor and the resulting date queued. valid drops when there is
  // nothing to offer or the sender idles; it is never lowered and raised in one step.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_blk
    date_cmd_t taken;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        taken.command    = in_bus.command;
        taken.load_day   = in_bus.load_day;
        taken.load_month = in_bus.load_month;
        taken.load_year  = in_bus.load_year;
        taken.day_count  = in_bus.day_count;
        model_date = advance_date(model_date, taken);
        expected_dates.push_back(model_date);
        cmd_tally[taken.command]++;
        accepted_count++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          taken = pending_cmds.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.command    <= taken.command;
          in_bus.load_day   <= taken.load_day;
          in_bus.load_month <= taken.load_month;
          in_bus.load_year  <= taken.load_year;
          in_bus.day_count  <= taken.day_count;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, forced low during the hold-off stretch.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_off) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Long hold-off at the start of the no-idle phase: the sender keeps offering,
  // the result register fills, one more command is taken, and then in_chan stalls.
  initial begin
    hold_off = 1'b0;
    wait (phase_id == 2);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result transfer is checked against the oldest expected date.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_blk
    cal_date_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_dates.size() == 0) begin
        report_mismatch("result with no command outstanding", 0, out_bus.cur_day);
      end else begin
        want = expected_dates.pop_front();
        if (out_bus.cur_day !== want.day)
          report_mismatch("cur_day", want.day, out_bus.cur_day);
        if (out_bus.cur_month !== want.month)
          report_mismatch("cur_month", want.month, out_bus.cur_month);
        if (out_bus.cur_year !== want.year)
          report_mismatch("cur_year", want.year, out_bus.cur_year);
        dates_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial begin
    #(TIMEOUT_NS);
    $display("[%0t] timeout: %0d dates still outstanding", $realtime,
             expected_dates.size());
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequencer: reset, directed corner cases, then three random phases with
  // different idling mixes.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.command    = '0;
    in_bus.load_day   = '0;
    in_bus.load_month = '0;
    in_bus.load_year  = '0;
    in_bus.day_count  = '0;
    out_bus.ready     = 1'b0;
    model_date.day    = 5'd1;
    model_date.month  = 4'd1;
    model_date.year   = YEAR_W'(1);
    send_idle_pct     = 16;
    recv_idle_pct     = 59;
    phase_id          = 0;
    queued_count      = 0;
    accepted_count    = 0;
    dates_checked     = 0;
    count_mismatches  = 0;
    foreach (cmd_tally[i]) cmd_tally[i] = 0;

    // a short walk straight from the reset date
    queue_cmd(CMD_ADD,  5'd7,  4'd3,  16'd99,    24'd40);
    // year wrap forwards and backwards
    queue_cmd(CMD_LOAD, 5'd31, 4'd12, 16'hFFFF,  24'hABCDEF);
    queue_cmd(CMD_NEXT, 5'd0,  4'd0,  16'h1234,  24'hFFFFFF);
    queue_cmd(CMD_PREV, 5'd31, 4'd15, 16'h0000,  24'h000001);
    queue_cmd(CMD_LOAD, 5'd1,  4'd1,  16'd0,     24'd0);
    queue_cmd(CMD_PREV, 5'd9,  4'd9,  16'h5555,  24'h555555);
    // load clamping: 31 February, zero fields, month above 12, 31 April
    queue_cmd(CMD_LOAD, 5'd31, 4'd2,  16'd2023,  24'd0);
    queue_cmd(CMD_NEXT, 5'd2,  4'd4,  16'd7,     24'd12);
    queue_cmd(CMD_PREV, 5'd3,  4'd5,  16'd8,     24'd13);
    queue_cmd(CMD_LOAD, 5'd0,  4'd0,  16'hAAAA,  24'd0);
    queue_cmd(CMD_LOAD, 5'd31, 4'd15, 16'd1999,  24'd5);
    queue_cmd(CMD_LOAD, 5'd31, 4'd4,  16'd2000,  24'd6);
    // zero counts, short walks inside one month, a month edge
    queue_cmd(CMD_ADD,  5'd1,  4'd1,  16'd1,     24'd0);
    queue_cmd(CMD_SUB,  5'd1,  4'd1,  16'd1,     24'd0);
    queue_cmd(CMD_ADD,  5'd4,  4'd4,  16'd4,     24'd1);
    queue_cmd(CMD_ADD,  5'd4,  4'd4,  16'd4,     24'd5);
    queue_cmd(CMD_SUB,  5'd4,  4'd4,  16'd4,     24'd3);
    // exactly around one year, then the largest count each way
    queue_cmd(CMD_ADD,  5'd0,  4'd0,  16'd0,     24'd364);
    queue_cmd(CMD_ADD,  5'd0,  4'd0,  16'd0,     24'd365);
    queue_cmd(CMD_SUB,  5'd0,  4'd0,  16'd0,     24'd365);
    queue_cmd(CMD_ADD,  5'd0,  4'd0,  16'd0,     24'hFFFFFF);
    queue_cmd(CMD_SUB,  5'd0,  4'd0,  16'd0,     24'hFFFFFF);
    // unused codes with busy fields
    queue_cmd(CMD_SPARE_FIRST,      5'd31, 4'd15, 16'hFFFF, 24'hFFFFFF);
    queue_cmd(CMD_SPARE_FIRST + 1'b1, 5'd17, 4'd6, 16'h8000, 24'h800000);
    queue_cmd(CMD_SPARE_LAST,       5'd0,  4'd0,  16'h0001, 24'h000365);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // phase 0: sender idles a little, receiver a lot
    repeat (PHASE_ITEMS) queue_random_cmd();
    while (accepted_count != queued_count) @(posedge clk);

    // phase 1: the other way round
    send_idle_pct = 59;
    recv_idle_pct = 16;
    phase_id      = 1;
    repeat (PHASE_ITEMS) queue_random_cmd();
    while (accepted_count != queued_count) @(posedge clk);

    // phase 2: no idling, opened by the long receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase_id      = 2;
    repeat (PHASE_ITEMS) queue_random_cmd();
    while (accepted_count != queued_count) @(posedge clk);

    while (expected_dates.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d commands: %0d load, %0d next, %0d prev, %0d add, %0d sub, %0d unused",
             accepted_count, cmd_tally[CMD_LOAD], cmd_tally[CMD_NEXT], cmd_tally[CMD_PREV],
             cmd_tally[CMD_ADD], cmd_tally[CMD_SUB],
             cmd_tally[5] + cmd_tally[6] + cmd_tally[7]);
    $display("%0d dates compared across three back-pressure mixes and a %0d-cycle hold-off, %0d mismatches",
             dates_checked, HOLD_CYCLES, count_mismatches);
    if (count_mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/cds_pkg.sv
rtl/cds_chan_if.sv
rtl/cds_ctrl.sv
rtl/cds_dpath.sv
rtl/calendar_date_stepper.sv
rtl/cds_checker.sv
test/tb_calendar_date_stepper.sv
